// File: hw/rtl/ndgps_pkg.sv
// types and constants shared by the grid position stepper
package ndgps_pkg;

    localparam int STORE_DIMS = 4;
    localparam int POS_W      = 9;
    localparam int SHIFT_W    = 16;
    localparam int LIN_W      = 33;
    localparam int MAG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [2:0] REQ_BEGIN = 3'd0;
    localparam logic [2:0] REQ_INC   = 3'd1;
    localparam logic [2:0] REQ_DEC   = 3'd2;
    localparam logic [2:0] REQ_ADD   = 3'd3;
    localparam logic [2:0] REQ_SUB   = 3'd4;
    localparam logic [2:0] REQ_SET   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS3   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC  = 3'd5;

    typedef logic [STORE_DIMS-1:0][POS_W-1:0] pos_vec_t;

    typedef struct packed {
        logic [2:0]                req_type;
        logic signed [SHIFT_W-1:0] shift_0;
        logic signed [SHIFT_W-1:0] shift_1;
        logic signed [SHIFT_W-1:0] shift_2;
        logic signed [SHIFT_W-1:0] shift_3;
        logic [1:0]                set_dim;
        logic [7:0]                set_value;
    } req_word_t;

    typedef struct packed {
        logic [POS_W-1:0] pos_0;
        logic [POS_W-1:0] pos_1;
        logic [POS_W-1:0] pos_2;
        logic [POS_W-1:0] pos_3;
        logic [LIN_W-1:0] linear_index;
        logic             at_end;
        logic             out_of_range;
    } rsp_word_t;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [POS_W-1:0] divisor;
    } mod_ctrl_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [POS_W-1:0] rem;
    } mod_stat_t;

endpackage

// File: hw/rtl/nd_grid_position_stepper_unit.sv
// grid position stepper top level: sequencer, config registers, shared multiplier
//
//  port group  dir  handshake          word
//  req         in   req_valid/ready    ndgps_pkg::req_word_t
//  rsp         out  rsp_valid/ready    ndgps_pkg::rsp_word_t
//  cfg         in   cfg_we             cfg_index, cfg_data
//
// a word passes the fix, op and linear index steps; shifts add a shift step per dimension and
// a serial remainder per periodic dimension (one bit a cycle), ending early once a shift leaves the range
// the linear index uses one multiplier twice per dimension
// req_ready is high only while idle; a finished word waits in the rsp register
// and the next word is taken meanwhile; no clearing pass after reset
module nd_grid_position_stepper_unit
#(
    parameter int MAX_DIMS   = 4,
    parameter int MAX_POINTS = 256
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    req_valid,
    output logic                                    req_ready,
    input  ndgps_pkg::req_word_t                    req_word,
    output logic                                    rsp_valid,
    input  logic                                    rsp_ready,
    output ndgps_pkg::rsp_word_t                    rsp_word,
    input  logic                                    cfg_we,
    input  logic [ndgps_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ndgps_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int DIM_LIM = (MAX_DIMS < ndgps_pkg::STORE_DIMS) ? MAX_DIMS
                                                                : ndgps_pkg::STORE_DIMS;
    localparam int POS_W = ndgps_pkg::POS_W;
    localparam int LIN_W = ndgps_pkg::LIN_W;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_FIX,
        ST_OP,
        ST_SHIFT,
        ST_WAIT,
        ST_LIN_P,
        ST_LIN_S,
        ST_DONE
    } state_t;

    state_t                     state_reg;
    logic [2:0]                 dim_count_reg;
    ndgps_pkg::pos_vec_t        points_reg;
    logic [3:0]                 periodic_reg;
    ndgps_pkg::pos_vec_t        pos_reg;
    ndgps_pkg::pos_vec_t        shifted_reg;
    ndgps_pkg::req_word_t       req_reg;
    logic [2:0]                 dim_reg;
    logic                       oor_reg;
    logic                       neg_reg;
    logic [LIN_W-1:0]           lin_reg;
    logic [LIN_W-1:0]           stride_reg;
    logic [LIN_W-1:0]           prod_reg;
    logic                       rsp_valid_reg;
    ndgps_pkg::rsp_word_t       rsp_reg;

    logic [2:0]                 nd;
    ndgps_pkg::pos_vec_t        cnt;
    ndgps_pkg::pos_vec_t        op_pos_next;
    logic                       op_oor_next;
    logic [1:0]                 dsel;
    logic [ndgps_pkg::SHIFT_W-1:0] shift_sel;
    logic signed [17:0]         idx;
    logic [17:0]                idx_mag;
    logic [POS_W-1:0]           wrap_val;
    logic [POS_W-1:0]           mul_a;
    logic [LIN_W-1:0]           mul_full;
    ndgps_pkg::mod_ctrl_t       mod_ctrl;
    ndgps_pkg::mod_stat_t       mod_stat;

    function automatic logic is_point(ndgps_pkg::pos_vec_t p, logic [2:0] n,
                                      ndgps_pkg::pos_vec_t c);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < ndgps_pkg::STORE_DIMS; i++)
        begin
            if (3'(i) < n)
            begin
                if (p[i] >= c[i]) ok = 1'b0;
            end
            else if (p[i] != '0)
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic is_end(ndgps_pkg::pos_vec_t p, logic [2:0] n,
                                    ndgps_pkg::pos_vec_t c);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < ndgps_pkg::STORE_DIMS; i++)
        begin
            if (3'(i) == n - 3'd1)
            begin
                if (p[i] != c[i]) ok = 1'b0;
            end
            else if (p[i] != '0)
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic ndgps_pkg::pos_vec_t end_pos(logic [2:0] n, ndgps_pkg::pos_vec_t c);
        ndgps_pkg::pos_vec_t p;
        p = '0;
        for (int i = 0; i < ndgps_pkg::STORE_DIMS; i++)
        begin
            if (3'(i) == n - 3'd1) p[i] = c[i];
        end
        return p;
    endfunction

    always_comb
    begin
        if (dim_count_reg == 3'd0)
        begin
            nd = 3'd1;
        end
        else if (32'(dim_count_reg) > DIM_LIM)
        begin
            nd = 3'(DIM_LIM);
        end
        else
        begin
            nd = dim_count_reg;
        end
        for (int i = 0; i < ndgps_pkg::STORE_DIMS; i++)
        begin
            if (points_reg[i] == '0)
            begin
                cnt[i] = POS_W'(1);
            end
            else if (32'(points_reg[i]) > MAX_POINTS)
            begin
                cnt[i] = POS_W'(MAX_POINTS);
            end
            else
            begin
                cnt[i] = points_reg[i];
            end
        end
    end

    // begin, increment, decrement and set are resolved combinationally from the current position
    always_comb
    begin
        logic found;
        logic all_zero;
        op_pos_next = pos_reg;
        op_oor_next = 1'b0;
        found       = 1'b0;
        all_zero    = 1'b1;
        unique case (req_reg.req_type)
            ndgps_pkg::REQ_BEGIN:
            begin
                op_pos_next = '0;
            end
            ndgps_pkg::REQ_INC:
            begin
                if (is_end(pos_reg, nd, cnt))
                begin
                    op_oor_next = 1'b1;
                end
                else
                begin
                    op_pos_next[0] = pos_reg[0] + POS_W'(1);
                    for (int i = 0; i < ndgps_pkg::STORE_DIMS - 1; i++)
                    begin
                        if (3'(i + 1) < nd && op_pos_next[i] >= cnt[i])
                        begin
                            op_pos_next[i]     = '0;
                            op_pos_next[i + 1] = op_pos_next[i + 1] + POS_W'(1);
                        end
                    end
                end
            end
            ndgps_pkg::REQ_DEC:
            begin
                for (int i = 0; i < ndgps_pkg::STORE_DIMS; i++)
                begin
                    if (3'(i) < nd && pos_reg[i] != '0) all_zero = 1'b0;
                end
                if (all_zero)
                begin
                    op_oor_next = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < ndgps_pkg::STORE_DIMS; i++)
                    begin
                        if (!found && 3'(i) < nd)
                        begin
                            if (pos_reg[i] == '0)
                            begin
                                op_pos_next[i] = cnt[i] - POS_W'(1);
                            end
                            else
                            begin
                                op_pos_next[i] = pos_reg[i] - POS_W'(1);
                                found          = 1'b1;
                            end
                        end
                    end
                end
            end
            ndgps_pkg::REQ_SET:
            begin
                if ({1'b0, req_reg.set_dim} < nd)
                begin
                    op_pos_next[req_reg.set_dim] = {1'b0, req_reg.set_value};
                    if (!is_point(op_pos_next, nd, cnt) && !is_end(op_pos_next, nd, cnt))
                    begin
                        op_pos_next = end_pos(nd, cnt);
                        op_oor_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign dsel = dim_reg[1:0];

    always_comb
    begin
        unique case (dsel)
            2'd0:    shift_sel = req_reg.shift_0;
            2'd1:    shift_sel = req_reg.shift_1;
            2'd2:    shift_sel = req_reg.shift_2;
            default: shift_sel = req_reg.shift_3;
        endcase
        if (req_reg.req_type == ndgps_pkg::REQ_ADD)
        begin
            idx = $signed({9'b0, pos_reg[dsel]}) + $signed({{2{shift_sel[15]}}, shift_sel});
        end
        else
        begin
            idx = $signed({9'b0, pos_reg[dsel]}) - $signed({{2{shift_sel[15]}}, shift_sel});
        end
        idx_mag = idx[17] ? (18'd0 - 18'(idx)) : 18'(idx);
        if (neg_reg && mod_stat.rem != '0)
        begin
            wrap_val = cnt[dsel] - mod_stat.rem;
        end
        else
        begin
            wrap_val = mod_stat.rem;
        end
        mod_ctrl.start    = (state_reg == ST_SHIFT) && !oor_reg && (dim_reg < nd)
                            && periodic_reg[dsel];
        mod_ctrl.dividend = idx_mag[ndgps_pkg::MAG_W-1:0];
        mod_ctrl.divisor  = cnt[dsel];
        mul_a    = (state_reg == ST_LIN_P) ? pos_reg[dsel] : cnt[dsel];
        mul_full = LIN_W'(mul_a) * stride_reg;
    end

    ndgps_mod u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mod_ctrl),
        .stat  (mod_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dim_count_reg <= 3'd1;
            points_reg    <= {ndgps_pkg::STORE_DIMS{POS_W'(256)}};
            periodic_reg  <= '0;
            pos_reg       <= '0;
            shifted_reg   <= '0;
            req_reg       <= '0;
            dim_reg       <= '0;
            oor_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            lin_reg       <= '0;
            stride_reg    <= '0;
            prod_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ndgps_pkg::CFG_DIM_COUNT: dim_count_reg <= cfg_data[2:0];
                    ndgps_pkg::CFG_POINTS0:   points_reg[0] <= cfg_data;
                    ndgps_pkg::CFG_POINTS1:   points_reg[1] <= cfg_data;
                    ndgps_pkg::CFG_POINTS2:   points_reg[2] <= cfg_data;
                    ndgps_pkg::CFG_POINTS3:   points_reg[3] <= cfg_data;
                    ndgps_pkg::CFG_PERIODIC:  periodic_reg  <= cfg_data[3:0];
                    default:                  periodic_reg  <= periodic_reg;
                endcase
            end

            if (state_reg == ST_DONE && (!rsp_valid_reg || rsp_ready))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg   <= req_word;
                        state_reg <= ST_FIX;
                    end
                end
                ST_FIX:
                begin
                    // stale position after a register change goes to the end
                    if (!is_point(pos_reg, nd, cnt) && !is_end(pos_reg, nd, cnt))
                    begin
                        pos_reg <= end_pos(nd, cnt);
                    end
                    state_reg <= ST_OP;
                end
                ST_OP:
                begin
                    dim_reg     <= '0;
                    neg_reg     <= 1'b0;
                    shifted_reg <= pos_reg;
                    lin_reg     <= '0;
                    stride_reg  <= LIN_W'(1);
                    if (req_reg.req_type == ndgps_pkg::REQ_ADD
                        || req_reg.req_type == ndgps_pkg::REQ_SUB)
                    begin
                        oor_reg   <= 1'b0;
                        state_reg <= ST_SHIFT;
                    end
                    else
                    begin
                        pos_reg   <= op_pos_next;
                        oor_reg   <= op_oor_next;
                        state_reg <= ST_LIN_P;
                    end
                end
                ST_SHIFT:
                begin
                    if (oor_reg || dim_reg >= nd)
                    begin
                        pos_reg    <= oor_reg ? end_pos(nd, cnt) : shifted_reg;
                        dim_reg    <= '0;
                        state_reg  <= ST_LIN_P;
                    end
                    else if (periodic_reg[dsel])
                    begin
                        neg_reg   <= idx[17];
                        state_reg <= ST_WAIT;
                    end
                    else if (idx[17] || idx[16:0] >= {8'b0, cnt[dsel]})
                    begin
                        oor_reg <= 1'b1;
                    end
                    else
                    begin
                        shifted_reg[dsel] <= idx[POS_W-1:0];
                        dim_reg           <= dim_reg + 3'd1;
                    end
                end
                ST_WAIT:
                begin
                    if (mod_stat.done)
                    begin
                        shifted_reg[dsel] <= wrap_val;
                        dim_reg           <= dim_reg + 3'd1;
                        state_reg         <= ST_SHIFT;
                    end
                end
                ST_LIN_P:
                begin
                    if (dim_reg >= nd)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        prod_reg  <= mul_full;
                        state_reg <= ST_LIN_S;
                    end
                end
                ST_LIN_S:
                begin
                    lin_reg    <= lin_reg + prod_reg;
                    stride_reg <= mul_full;
                    dim_reg    <= dim_reg + 3'd1;
                    state_reg  <= ST_LIN_P;
                end
                ST_DONE:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_reg.pos_0        <= pos_reg[0];
                        rsp_reg.pos_1        <= pos_reg[1];
                        rsp_reg.pos_2        <= pos_reg[2];
                        rsp_reg.pos_3        <= pos_reg[3];
                        rsp_reg.linear_index <= lin_reg;
                        rsp_reg.at_end       <= is_end(pos_reg, nd, cnt);
                        rsp_reg.out_of_range <= oor_reg;
                        state_reg            <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

    a_idle_mod_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mod_stat.busy)
        else $error("remainder unit busy while idle");

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("ready stayed high after a word was taken");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("response raised outside the done step");

    a_wait_has_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT && !mod_stat.done) |-> mod_stat.busy)
        else $error("waiting on an idle remainder unit");

endmodule

// File: hw/rtl/ndgps_mod.sv
// bit-serial restoring remainder unit for periodic wrap
module ndgps_mod
(
    input  logic                clk,
    input  logic                rst_n,
    input  ndgps_pkg::mod_ctrl_t ctrl,
    output ndgps_pkg::mod_stat_t stat
);

    logic [ndgps_pkg::MAG_W-1:0] quo_reg;
    logic [ndgps_pkg::POS_W-1:0] rem_reg;
    logic [ndgps_pkg::POS_W-1:0] div_reg;
    logic [3:0]                  bit_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [ndgps_pkg::POS_W:0]   trial;
    logic [ndgps_pkg::POS_W-1:0] rem_next;

    always_comb
    begin
        trial = {rem_reg, quo_reg[ndgps_pkg::MAG_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = ndgps_pkg::POS_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[ndgps_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            bit_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                quo_reg  <= ctrl.dividend;
                div_reg  <= ctrl.divisor;
                rem_reg  <= '0;
                bit_reg  <= 4'(ndgps_pkg::MAG_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[ndgps_pkg::MAG_W-2:0], 1'b0};
                bit_reg <= bit_reg - 4'd1;
                if (bit_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule

// File: bench/tb_nd_grid_position_stepper_unit.sv
// self-checking testbench for the grid position stepper: directed table, then random phases
module tb_nd_grid_position_stepper_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int      PERIOD   = 8;
    localparam int      NDIR     = 29;
    localparam int      NPHASES  = 10;
    localparam int      PHASE_N  = 70;
    localparam int      HOLD_CYC = 400;
    localparam longint  LIMIT_NS = 5_000_000;

    localparam int STORE_DIMS = ndgps_pkg::STORE_DIMS;
    localparam int POS_W      = ndgps_pkg::POS_W;
    localparam int SHIFT_W    = ndgps_pkg::SHIFT_W;
    localparam int LIN_W      = ndgps_pkg::LIN_W;
    localparam int CFG_IDX_W  = ndgps_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ndgps_pkg::CFG_DATA_W;

    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER [6] = '{ndgps_pkg::CFG_DIM_COUNT,
        ndgps_pkg::CFG_POINTS0, ndgps_pkg::CFG_POINTS1, ndgps_pkg::CFG_POINTS2,
        ndgps_pkg::CFG_POINTS3, ndgps_pkg::CFG_PERIODIC};

    typedef logic [5:0][CFG_DATA_W-1:0] setting_t;

    typedef struct packed {
        logic                 is_cfg;
        setting_t             cfg_val;
        ndgps_pkg::req_word_t word;
        logic                 typed;
        ndgps_pkg::rsp_word_t want;
    } step_row_t;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    ndgps_pkg::req_word_t req_word;
    logic      rsp_valid;
    logic      rsp_ready;
    ndgps_pkg::rsp_word_t rsp_word;
    logic      cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor copy of the registers and position
    logic [2:0]       cfg_dims;
    logic [8:0]       cfg_points [4];
    logic [3:0]       cfg_wrap;
    logic [POS_W-1:0] grid_pos [4];

    ndgps_pkg::rsp_word_t expected_pos_q [$];
    ndgps_pkg::rsp_word_t want_rsp;
    step_row_t dir_tbl [NDIR];
    int        words_sent;
    int        results_checked;
    int        mismatches;
    int        settings_used;
    int        run_left;
    logic [2:0] run_type;
    bit        hold_rsp;

    nd_grid_position_stepper_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(PERIOD / 2) clk = ~clk;

    function automatic int dims_used();
        int d;
        d = cfg_dims;
        if (d < 1) d = 1;
        if (d > STORE_DIMS) d = STORE_DIMS;
        return d;
    endfunction

    function automatic int count_at(int i);
        int p;
        p = cfg_points[i];
        if (p < 1) p = 1;
        if (p > 256) p = 256;
        return p;
    endfunction

    function automatic bit on_point(int nd);
        for (int i = 0; i < STORE_DIMS; i++)
        begin
            if (i < nd)
            begin
                if (grid_pos[i] >= count_at(i)) return 1'b0;
            end
            else if (grid_pos[i] != 0)
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit on_end(int nd);
        for (int i = 0; i < STORE_DIMS; i++)
        begin
            if (grid_pos[i] != ((i == nd - 1) ? count_at(i) : 0)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void jump_end(int nd);
        for (int i = 0; i < STORE_DIMS; i++) grid_pos[i] = '0;
        grid_pos[nd - 1] = POS_W'(count_at(nd - 1));
    endfunction

    function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        case (idx)
            ndgps_pkg::CFG_DIM_COUNT: cfg_dims      = v[2:0];
            ndgps_pkg::CFG_POINTS0:   cfg_points[0] = v;
            ndgps_pkg::CFG_POINTS1:   cfg_points[1] = v;
            ndgps_pkg::CFG_POINTS2:   cfg_points[2] = v;
            ndgps_pkg::CFG_POINTS3:   cfg_points[3] = v;
            ndgps_pkg::CFG_PERIODIC:  cfg_wrap      = v[3:0];
            default: ;
        endcase
    endfunction

    // next position for one word; updates the predictor position
    function automatic ndgps_pkg::rsp_word_t step_position(ndgps_pkg::req_word_t w);
        int         nd, n, k, cur, idx;
        int         sh [4];
        bit         oor, zero;
        logic [POS_W-1:0] nxt [4];
        longint     lin, stride;
        ndgps_pkg::rsp_word_t r;
        nd = dims_used();
        oor = 1'b0;
        sh[0] = $signed(w.shift_0);
        sh[1] = $signed(w.shift_1);
        sh[2] = $signed(w.shift_2);
        sh[3] = $signed(w.shift_3);
        if (!on_point(nd) && !on_end(nd)) jump_end(nd);
        case (w.req_type)
            ndgps_pkg::REQ_BEGIN:
                for (k = 0; k < STORE_DIMS; k++) grid_pos[k] = '0;
            ndgps_pkg::REQ_INC:
                if (on_end(nd)) oor = 1'b1;
                else
                begin
                    grid_pos[0] = grid_pos[0] + 1'b1;
                    for (k = 0; k + 1 < nd; k++)
                    begin
                        if (grid_pos[k] >= count_at(k))
                        begin
                            grid_pos[k]     = '0;
                            grid_pos[k + 1] = grid_pos[k + 1] + 1'b1;
                        end
                    end
                end
            ndgps_pkg::REQ_DEC:
            begin
                zero = 1'b1;
                for (k = 0; k < nd; k++) if (grid_pos[k] != 0) zero = 1'b0;
                if (zero) oor = 1'b1;
                else
                begin
                    k = 0;
                    while (k < nd && grid_pos[k] == 0)
                    begin
                        grid_pos[k] = POS_W'(count_at(k) - 1);
                        k++;
                    end
                    if (k < nd) grid_pos[k] = grid_pos[k] - 1'b1;
                end
            end
            ndgps_pkg::REQ_ADD, ndgps_pkg::REQ_SUB:
            begin
                nxt = grid_pos;
                for (k = 0; k < nd; k++)
                begin
                    n   = count_at(k);
                    cur = grid_pos[k];
                    idx = (w.req_type == ndgps_pkg::REQ_ADD) ? cur + sh[k] : cur - sh[k];
                    if (cfg_wrap[k])
                    begin
                        idx = idx % n;
                        if (idx < 0) idx += n;
                    end
                    else if (idx < 0 || idx >= n)
                    begin
                        oor = 1'b1;
                        break;
                    end
                    nxt[k] = POS_W'(idx);
                end
                if (oor) jump_end(nd);
                else grid_pos = nxt;
            end
            ndgps_pkg::REQ_SET:
                if (int'(w.set_dim) < nd)
                begin
                    grid_pos[w.set_dim] = {1'b0, w.set_value};
                    if (!on_point(nd) && !on_end(nd))
                    begin
                        jump_end(nd);
                        oor = 1'b1;
                    end
                end
            default: ;
        endcase
        lin = 0;
        stride = 1;
        for (k = 0; k < nd; k++)
        begin
            lin += longint'(grid_pos[k]) * stride;
            stride *= count_at(k);
        end
        r.pos_0        = grid_pos[0];
        r.pos_1        = grid_pos[1];
        r.pos_2        = grid_pos[2];
        r.pos_3        = grid_pos[3];
        r.linear_index = lin[LIN_W-1:0];
        r.at_end       = on_end(nd);
        r.out_of_range = oor;
        return r;
    endfunction

    function automatic setting_t pack_setting(int dc, int p0, int p1, int p2, int p3, int m);
        setting_t v;
        v[0] = CFG_DATA_W'(dc);
        v[1] = CFG_DATA_W'(p0);
        v[2] = CFG_DATA_W'(p1);
        v[3] = CFG_DATA_W'(p2);
        v[4] = CFG_DATA_W'(p3);
        v[5] = CFG_DATA_W'(m);
        return v;
    endfunction

    function automatic step_row_t cfg_row(int dc, int p0, int p1, int p2, int p3, int m);
        step_row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.cfg_val = pack_setting(dc, p0, p1, p2, p3, m);
        return r;
    endfunction

    function automatic step_row_t req_row(logic [2:0] t, int s0, int s1, int s2, int s3);
        step_row_t r;
        r = '0;
        r.word.req_type = t;
        r.word.shift_0  = SHIFT_W'(s0);
        r.word.shift_1  = SHIFT_W'(s1);
        r.word.shift_2  = SHIFT_W'(s2);
        r.word.shift_3  = SHIFT_W'(s3);
        return r;
    endfunction

    function automatic step_row_t set_row(int sd, int sv);
        step_row_t r;
        r = '0;
        r.word.req_type  = ndgps_pkg::REQ_SET;
        r.word.set_dim   = 2'(sd);
        r.word.set_value = 8'(sv);
        return r;
    endfunction

    // one-dimensional rows whose result is obvious
    function automatic step_row_t known_row(step_row_t r, int p0, longint lin, bit e, bit o);
        step_row_t k;
        k = r;
        k.typed             = 1'b1;
        k.want.pos_0        = POS_W'(p0);
        k.want.linear_index = lin[LIN_W-1:0];
        k.want.at_end       = e;
        k.want.out_of_range = o;
        return k;
    endfunction

    function automatic setting_t random_setting(int ph);
        int dc, pick;
        int p [4];
        case (ph)
            0: return pack_setting(4, 256, 256, 256, 256, $urandom_range(0, 15));
            1: return pack_setting(4, 1, 1, 1, 1, $urandom_range(0, 15));
            2:
            begin
                pick = $urandom_range(0, 3);
                dc = (pick == 0) ? 0 : 4 + pick;
                foreach (p[i]) p[i] = $urandom_range(0, 1) ? 0 : $urandom_range(257, 511);
            end
            default:
            begin
                dc = $urandom_range(1, 4);
                foreach (p[i])
                    p[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 256)
                                                       : $urandom_range(1, 6);
            end
        endcase
        return pack_setting(dc, p[0], p[1], p[2], p[3], $urandom_range(0, 15));
    endfunction

    function automatic ndgps_pkg::req_word_t next_word();
        ndgps_pkg::req_word_t w;
        int        nd, sel, n, tgt, delta, style;
        int        sh [4];
        nd = dims_used();
        foreach (sh[i]) sh[i] = $urandom_range(0, 65535);
        w.req_type  = 3'($urandom);
        w.set_dim   = 2'($urandom);
        w.set_value = 8'($urandom);
        if (run_left > 0)
        begin
            run_left--;
            w.req_type = run_type;
        end
        else
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8) w.req_type = ndgps_pkg::REQ_BEGIN;
            else if (sel < 30) w.req_type = ndgps_pkg::REQ_INC;
            else if (sel < 48) w.req_type = ndgps_pkg::REQ_DEC;
            else if (sel < 62) w.req_type = ndgps_pkg::REQ_ADD;
            else if (sel < 76) w.req_type = ndgps_pkg::REQ_SUB;
            else if (sel < 92) w.req_type = ndgps_pkg::REQ_SET;
            else w.req_type = $urandom_range(0, 1) ? REQ_SPARE6 : REQ_SPARE7;
            if ((w.req_type == ndgps_pkg::REQ_INC || w.req_type == ndgps_pkg::REQ_DEC)
                && $urandom_range(0, 4) == 0)
            begin
                run_left = $urandom_range(3, 24);
                run_type = w.req_type;
            end
        end
        if (w.req_type == ndgps_pkg::REQ_ADD || w.req_type == ndgps_pkg::REQ_SUB)
        begin
            style = $urandom_range(0, 9);
            for (int k = 0; k < nd && style < 9; k++)
            begin
                n = count_at(k);
                if (style < 6)
                begin
                    // land inside the grid, with extra laps on wrapping dimensions
                    tgt = $urandom_range(0, n - 1);
                    if (cfg_wrap[k]) tgt += n * (int'($urandom_range(0, 6)) - 3);
                    delta = tgt - int'(grid_pos[k]);
                    sh[k] = (w.req_type == ndgps_pkg::REQ_ADD) ? delta : -delta;
                end
                else
                begin
                    sh[k] = int'($urandom_range(0, 2 * n + 2)) - (n + 1);
                end
            end
        end
        if (w.req_type == ndgps_pkg::REQ_SET && $urandom_range(0, 9) < 7)
        begin
            n = count_at(w.set_dim);
            w.set_value = 8'($urandom_range(0, (n > 255) ? 255 : n));
        end
        w.shift_0 = SHIFT_W'(sh[0]);
        w.shift_1 = SHIFT_W'(sh[1]);
        w.shift_2 = SHIFT_W'(sh[2]);
        w.shift_3 = SHIFT_W'(sh[3]);
        return w;
    endfunction

    task automatic send(ndgps_pkg::req_word_t w, bit typed, ndgps_pkg::rsp_word_t known);
        ndgps_pkg::rsp_word_t pred;
        req_valid <= 1'b1;
        req_word  <= w;
        do @(posedge clk); while (!req_ready);
        pred = step_position(w);
        expected_pos_q.push_back(typed ? known : pred);
        words_sent++;
    endtask

    task automatic drain(int tail);
        while (expected_pos_q.size() != 0) @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic apply_config(setting_t vals);
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_ORDER[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            write_reg(CFG_ORDER[i], vals[i]);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(int n_items, bit back_to_back);
        int left, burst, gap;
        left = n_items;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0)
            begin
                send(next_word(), 1'b0, '0);
                burst--;
                left--;
            end
            gap = back_to_back ? 0 : $urandom_range(0, 20);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_valid <= 1'b0;
    endtask

    function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_pos_q.size() == 0)
            begin
                $display("%0t ns: word out with nothing outstanding", $time);
                mismatches++;
            end
            else
            begin
                want_rsp = expected_pos_q.pop_front();
                cmp_field("pos_0", want_rsp.pos_0, rsp_word.pos_0);
                cmp_field("pos_1", want_rsp.pos_1, rsp_word.pos_1);
                cmp_field("pos_2", want_rsp.pos_2, rsp_word.pos_2);
                cmp_field("pos_3", want_rsp.pos_3, rsp_word.pos_3);
                cmp_field("linear_index", want_rsp.linear_index, rsp_word.linear_index);
                cmp_field("at_end", want_rsp.at_end, rsp_word.at_end);
                cmp_field("out_of_range", want_rsp.out_of_range, rsp_word.out_of_range);
                results_checked++;
            end
        end
    end

    initial
    begin : rsp_side
        rx_mode_t mode;
        int       span;
        rsp_ready = 1'b0;
        mode = RX_OPEN;
        span = 0;
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(20, 80);
                end
                span--;
                case (mode)
                    RX_OPEN:   rsp_ready <= 1'b1;
                    RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
                    default:   rsp_ready <= (span % 8 < 4);
                endcase
            end
        end
    end

    initial
    begin
        #LIMIT_NS;
        $display("tb_nd_grid_position_stepper_unit: done, errors");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_word  = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        hold_rsp  = 1'b0;
        run_left  = 0;
        run_type  = ndgps_pkg::REQ_INC;
        words_sent = 0;
        results_checked = 0;
        mismatches = 0;
        settings_used = 1;
        cfg_dims = 3'd1;
        cfg_wrap = '0;
        foreach (cfg_points[i]) cfg_points[i] = 9'd256;
        foreach (grid_pos[i]) grid_pos[i] = '0;

        dir_tbl = '{
            known_row(req_row(ndgps_pkg::REQ_BEGIN, 0, 0, 0, 0),      0,   0, 1'b0, 1'b0),
            known_row(req_row(ndgps_pkg::REQ_DEC, 0, 0, 0, 0),        0,   0, 1'b0, 1'b1),
            known_row(req_row(ndgps_pkg::REQ_INC, 0, 0, 0, 0),        1,   1, 1'b0, 1'b0),
            known_row(req_row(ndgps_pkg::REQ_ADD, 254, 0, 0, 0),    255, 255, 1'b0, 1'b0),
            known_row(req_row(ndgps_pkg::REQ_INC, 0, 0, 0, 0),      256, 256, 1'b1, 1'b0),
            known_row(req_row(ndgps_pkg::REQ_INC, 0, 0, 0, 0),      256, 256, 1'b1, 1'b1),
            known_row(req_row(ndgps_pkg::REQ_DEC, 0, 0, 0, 0),      255, 255, 1'b0, 1'b0),
            known_row(req_row(ndgps_pkg::REQ_ADD, 32767, 0, 0, 0),  256, 256, 1'b1, 1'b1),
            known_row(req_row(ndgps_pkg::REQ_SUB, 1, 0, 0, 0),      255, 255, 1'b0, 1'b0),
            known_row(req_row(ndgps_pkg::REQ_SUB, -32768, 0, 0, 0), 256, 256, 1'b1, 1'b1),
            known_row(set_row(0, 255),                              255, 255, 1'b0, 1'b0),
            known_row(set_row(2, 7),                                255, 255, 1'b0, 1'b0),
            known_row(req_row(REQ_SPARE6, 0, 0, 0, 0),              255, 255, 1'b0, 1'b0),
            cfg_row(4, 256, 256, 256, 256, 4'b0000),
            set_row(1, 255),
            set_row(2, 255),
            set_row(3, 255),
            req_row(ndgps_pkg::REQ_INC, 0, 0, 0, 0),
            cfg_row(3, 3, 2, 4, 511, 4'b0101),
            req_row(ndgps_pkg::REQ_ADD, 1, -1, 5, 0),
            req_row(ndgps_pkg::REQ_BEGIN, 0, 0, 0, 0),
            req_row(ndgps_pkg::REQ_SUB, -7, -1, -9, 0),
            set_row(1, 2),
            cfg_row(0, 0, 0, 0, 0, 4'b1111),
            req_row(ndgps_pkg::REQ_DEC, 0, 0, 0, 0),
            cfg_row(7, 2, 2, 2, 2, 4'b0000),
            req_row(ndgps_pkg::REQ_BEGIN, 0, 0, 0, 0),
            req_row(ndgps_pkg::REQ_ADD, 1, 1, 1, 1),
            req_row(ndgps_pkg::REQ_INC, 0, 0, 0, 0)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tbl[r])
        begin
            if (dir_tbl[r].is_cfg)
            begin
                req_valid <= 1'b0;
                drain(4);
                apply_config(dir_tbl[r].cfg_val);
            end
            else
            begin
                send(dir_tbl[r].word, dir_tbl[r].typed, dir_tbl[r].want);
            end
        end
        req_valid <= 1'b0;

        for (int ph = 0; ph < NPHASES; ph++)
        begin
            drain(4);
            apply_config(random_setting(ph));
            // long output stall while words keep coming
            if (ph == 3) hold_rsp = 1'b1;
            run_random(PHASE_N, ph % 3 == 0);
        end

        drain(100);
        $display("%0d request words under %0d register settings, %0d responses compared",
                 words_sent, settings_used, results_checked);
        $display("directed extremes and wrap/range cases, then random walks and shifts");
        if (mismatches == 0 && expected_pos_q.size() == 0)
            $display("tb_nd_grid_position_stepper_unit: done, clean");
        else
            $display("tb_nd_grid_position_stepper_unit: done, errors");
        $finish;
    end

endmodule
